[src/b14e_pkg.sv]
// Shared types and constants for the byte to 14-bit symbol encoder.
// No dependencies; imported by the core, the queue, the top level and the testbench.
package b14e_pkg;

  localparam logic [15:0] SymbolBase  = 16'h4E00;
  localparam logic [15:0] TrailerBase = 16'h3D00;
  localparam int unsigned GroupBits   = 14;
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned AccBits     = GroupBits - 1;          // leftover bits between bytes
  localparam int unsigned WideBits    = AccBits + ByteBits;     // leftover plus new byte
  localparam int unsigned HeldBits    = 4;                      // counts 0..13
  localparam int unsigned WideCntBits = 5;                      // counts 0..21
  localparam int unsigned PosBits     = 3;
  localparam logic [PosBits-1:0] LastPos = 3'd6;                // bytes per block minus one
  localparam int unsigned BurstMax    = 3;
  localparam int unsigned CntBits     = 2;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned OccBits     = 3;

  typedef struct packed {
    logic [ByteBits-1:0] data_byte;
    logic                end_of_input;
  } item_t;

  typedef struct packed {
    logic [15:0] symbol;
    logic        last_of_stream;
  } word_t;

  // Words produced by one byte, packed from index 0 upward.
  typedef struct packed {
    logic [CntBits-1:0]           count;
    word_t [BurstMax-1:0]         words;
  } burst_t;

endpackage

[src/b14e_core.sv]
// Input register, bit accumulator and symbol generation for one byte.
// Depends on b14e_pkg.
module b14e_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  b14e_pkg::item_t item_i,
  input  logic           room_i,
  output logic           push_o,
  output b14e_pkg::burst_t burst_o
);
  import b14e_pkg::*;

  logic                   s1_valid_q;
  item_t                  s1_item_q;
  logic [AccBits-1:0]     acc_q, acc_d;
  logic [HeldBits-1:0]    held_q, held_d;
  logic [PosBits-1:0]     pos_q, pos_d;

  logic                   advance;
  logic [WideBits-1:0]    acc_w;
  logic [WideCntBits-1:0] held_w;
  logic                   full;
  logic [WideCntBits-1:0] held_r;
  logic [WideBits-1:0]    rem_mask;
  logic [AccBits-1:0]     rem;
  logic [GroupBits-1:0]   grp_full;
  logic [GroupBits-1:0]   grp_pad;
  logic [PosBits-1:0]     pos_n;

  assign advance    = s1_valid_q && room_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign push_o     = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= item_i;
    end
  end

  always_comb begin
    acc_w    = {acc_q, s1_item_q.data_byte};
    held_w   = {1'b0, held_q} + WideCntBits'(ByteBits);
    full     = held_w >= WideCntBits'(GroupBits);
    grp_full = GroupBits'(acc_w >> (held_w - WideCntBits'(GroupBits)));
    held_r   = full ? held_w - WideCntBits'(GroupBits) : held_w;
    rem_mask = (WideBits'(1) << held_r) - WideBits'(1);
    rem      = AccBits'(acc_w & rem_mask);
    // pad leftover bits with zeros on the right
    grp_pad  = GroupBits'({1'b0, rem} << (WideCntBits'(GroupBits) - held_r));
    pos_n    = (pos_q == LastPos) ? '0 : pos_q + PosBits'(1);
  end

  // Pack the emitted words in order: full group, padded group, trailer.
  always_comb begin
    burst_o = '0;
    if (full) begin
      burst_o.words[burst_o.count] = '{symbol: SymbolBase + {2'b00, grp_full},
                                       last_of_stream: 1'b0};
      burst_o.count = burst_o.count + CntBits'(1);
    end
    if (s1_item_q.end_of_input && held_r != '0) begin
      burst_o.words[burst_o.count] = '{symbol: SymbolBase + {2'b00, grp_pad},
                                       last_of_stream: 1'b0};
      burst_o.count = burst_o.count + CntBits'(1);
    end
    if (s1_item_q.end_of_input && pos_n != '0) begin
      burst_o.words[burst_o.count] = '{symbol: TrailerBase + {13'd0, pos_n},
                                       last_of_stream: 1'b0};
      burst_o.count = burst_o.count + CntBits'(1);
    end
    if (s1_item_q.end_of_input && burst_o.count != '0) begin
      burst_o.words[burst_o.count - CntBits'(1)].last_of_stream = 1'b1;
    end
  end

  always_comb begin
    if (s1_item_q.end_of_input) begin
      acc_d  = '0;
      held_d = '0;
      pos_d  = '0;
    end else begin
      acc_d  = rem;
      held_d = HeldBits'(held_r);
      pos_d  = pos_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      pos_q  <= '0;
    end else if (advance) begin
      acc_q  <= acc_d;
      held_q <= held_d;
      pos_q  <= pos_d;
    end
  end

endmodule

[src/b14e_queue.sv]
// Four-entry result queue: up to three words in at once, one out a cycle if ready.
// Depends on b14e_pkg.
module b14e_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b14e_pkg::burst_t burst_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output b14e_pkg::word_t  head_o
);
  import b14e_pkg::*;

  word_t              ent_q [QDepth];
  word_t              ent_d [QDepth];
  logic [OccBits-1:0] occ_q, occ_d;
  logic [OccBits-1:0] base;
  logic [OccBits-1:0] off;
  logic               pop;

  assign pop         = (occ_q != '0) && out_ready_i;
  assign out_valid_o = occ_q != '0;
  assign head_o      = ent_q[0];
  // room for a full burst even if nothing drains this cycle
  assign room_o      = occ_q <= OccBits'(QDepth - BurstMax);

  always_comb begin
    base = occ_q - OccBits'(pop);
    off  = '0;
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      off = OccBits'(i) - base;
      if (push_i && OccBits'(i) >= base && off < {1'b0, burst_i.count}) begin
        ent_d[i] = burst_i.words[CntBits'(off)];
      end
    end
    occ_d = base + (push_i ? {1'b0, burst_i.count} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

endmodule

[src/bytes_to_14bit_symbol_encoder.sv]
// Channel  | signals                              | direction
// request  | in_valid_i/in_ready_o, data_byte_i,  | in
//          | end_of_input_i                       |
// result   | out_valid_o/out_ready_i, symbol_o,   | out
//          | last_of_stream_o                     |
//
// One byte a cycle while the queue has room; each byte is registered in the core
// before it is queued. A final byte makes up to three words, which drain one
// a cycle from the four-entry queue while out_ready_i is high; input holds while a
// byte waits and under three entries are free. Reset clears the accumulator and
// empties the queue. Top level; depends on b14e_pkg, b14e_core and b14e_queue.
module bytes_to_14bit_symbol_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] symbol_o,
  output logic        last_of_stream_o
);
  import b14e_pkg::*;

  item_t  item;
  burst_t burst;
  word_t  head;
  logic   push;
  logic   room;

  assign item = '{data_byte: data_byte_i, end_of_input: end_of_input_i};

  b14e_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item),
    .room_i     (room),
    .push_o     (push),
    .burst_o    (burst)
  );

  b14e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .burst_i     (burst),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign symbol_o         = head.symbol;
  assign last_of_stream_o = head.last_of_stream;

endmodule

[src/b14e_checker.sv]
// Port-level checks for the encoder top level, with its bind statement.
// Depends on bytes_to_14bit_symbol_encoder ports only.
module b14e_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] symbol_o,
  input logic        last_of_stream_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(symbol_o) && $stable(last_of_stream_o))
    else $error("result changed while stalled");

  // only a queue without room for a full burst, with a byte waiting, can hold off input
  a_ready_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // words before the end of a stream are always data symbols
  a_mid_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_stream_o |-> symbol_o >= 16'h4E00 && symbol_o <= 16'h8DFF)
    else $error("non-final word outside symbol range");

  // the last word is a data symbol or a trailer with a count of one to six
  a_last_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_stream_o |->
      (symbol_o >= 16'h4E00 && symbol_o <= 16'h8DFF) ||
      (symbol_o >= 16'h3D01 && symbol_o <= 16'h3D06))
    else $error("final word out of range");

endmodule

bind bytes_to_14bit_symbol_encoder b14e_checker u_b14e_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .symbol_o         (symbol_o),
  .last_of_stream_o (last_of_stream_o)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for bytes_to_14bit_symbol_encoder: random byte streams, a local
// encoder model and an in-order check of every symbol. Depends on b14e_pkg.
module testbench;
  import b14e_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 4;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] symbol_o;
  logic        last_of_stream_o;

  bytes_to_14bit_symbol_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_input_i  (end_of_input_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_o        (symbol_o),
    .last_of_stream_o(last_of_stream_o)
  );

  // Encoder state mirrored from the block
  logic [20:0] acc_bits;
  logic [4:0]  held_cnt;
  logic [2:0]  byte_pos;
  word_t       expected_words[$];

  int unsigned error_count;
  int unsigned cycle_count;
  bit          tx_gaps_en;
  bit          rx_stalls_en;
  int          stall_left;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap(bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap(rx_stalls_en);
    end
  end

  // Work out the symbols one accepted byte produces and queue them
  function automatic void encode_byte(logic [7:0] b, logic eoi);
    word_t       w[3];
    int          n;
    logic [31:0] grp;
    n = 0;
    acc_bits = {acc_bits[12:0], b};
    held_cnt = held_cnt + 5'd8;
    byte_pos = (byte_pos == LastPos) ? 3'd0 : byte_pos + 3'd1;
    if (held_cnt >= 5'd14) begin
      grp = (32'(acc_bits) >> (held_cnt - 5'd14)) & 32'h3FFF;
      w[n] = '{symbol: SymbolBase + grp[15:0], last_of_stream: 1'b0};
      n++;
      held_cnt = held_cnt - 5'd14;
      acc_bits = acc_bits & ((21'd1 << held_cnt) - 21'd1);
    end
    if (eoi) begin
      if (held_cnt != 5'd0) begin
        grp = (32'(acc_bits) << (5'd14 - held_cnt)) & 32'h3FFF;
        w[n] = '{symbol: SymbolBase + grp[15:0], last_of_stream: 1'b0};
        n++;
      end
      if (byte_pos != 3'd0) begin
        w[n] = '{symbol: TrailerBase + 16'(byte_pos), last_of_stream: 1'b0};
        n++;
      end
      if (n > 0) w[n-1].last_of_stream = 1'b1;
      acc_bits = '0;
      held_cnt = '0;
      byte_pos = '0;
    end
    for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Check results first, then predict from the request taken at the same edge
  always @(posedge clk_i) begin : check_proc
    word_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected symbol", symbol_o, 16'h0);
        end else begin
          w = expected_words.pop_front();
          if (symbol_o !== w.symbol)
            report_mismatch("symbol", symbol_o, w.symbol);
          if (last_of_stream_o !== w.last_of_stream)
            report_mismatch("last_of_stream", 16'(last_of_stream_o), 16'(w.last_of_stream));
        end
      end
      if (in_valid_i && in_ready_o) encode_byte(data_byte_i, end_of_input_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int gap;
    gap = pick_gap(tx_gaps_en);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_stream(input byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Hold the sender until every expected symbol is out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_streams(input int n_items);
    byte_q_t bytes;
    int      len;
    int      sent;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 9) : $urandom_range(10, 30);
      bytes = {};
      repeat (len) bytes.push_back(8'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        // pause mid stream until all output is out
        send_byte(bytes[0], len == 1);
        wait_drained();
        for (int i = 1; i < len; i++) send_byte(bytes[i], i == len - 1);
      end else begin
        send_stream(bytes);
      end
      sent += len;
    end
  endtask

  // Field extremes and stream lengths 1, 2, 3, 5, 6 and 7 (a whole block)
  task automatic test_directed();
    tx_gaps_en   = 1'b0;
    rx_stalls_en = 1'b0;
    send_stream('{8'h00});
    send_stream('{8'hFF});
    send_stream('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_stream('{8'h80, 8'h01});
    send_stream('{8'h00, 8'hFF, 8'h7F});
    send_stream('{8'hAA, 8'h55, 8'h01, 8'h80, 8'hFE});
    send_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
    wait_drained();
  endtask

  task automatic test_random_gaps();
    tx_gaps_en   = 1'b1;
    rx_stalls_en = 1'b1;
    run_streams(40);
    wait_drained();
  endtask

  task automatic test_full_rate();
    tx_gaps_en   = 1'b0;
    rx_stalls_en = 1'b0;
    run_streams(12);
    wait_drained();
  endtask

  task automatic test_receiver_stalls();
    tx_gaps_en   = 1'b0;
    rx_stalls_en = 1'b1;
    run_streams(8);
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'h00;
    end_of_input_i = 1'b0;
    out_ready_i    = 1'b0;
    stall_left     = 0;
    error_count    = 0;
    cycle_count    = 0;
    tx_gaps_en     = 1'b0;
    rx_stalls_en   = 1'b0;
    acc_bits       = '0;
    held_cnt       = '0;
    byte_pos       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_gaps();
    test_full_rate();
    test_receiver_stalls();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/b14e_pkg.sv
src/b14e_core.sv
src/b14e_queue.sv
src/bytes_to_14bit_symbol_encoder.sv
src/b14e_checker.sv
test/testbench.sv
